FILE: rtl/core/pstt_pkg.sv
// Shared types and constants for the priority sorted task table.
package pstt_pkg;

  localparam int DEPTH = 16;
  localparam int IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int PosW  = 4;
  localparam int CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam int OutCntW = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] pri;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               ok;
    logic [7:0]         id;
    logic [7:0]         pri;
    logic [OutCntW-1:0] count;
  } rsp_t;

endpackage

FILE: rtl/core/pstt_if.sv
// Request and response channel interfaces of the task table.
interface pstt_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] task_id;
  logic [7:0] task_priority;
  logic [3:0] position;

  modport source (output valid, operation, task_id, task_priority, position, input ready);
  modport sink (input valid, operation, task_id, task_priority, position, output ready);
endinterface

interface pstt_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [7:0] read_task_id;
  logic [7:0] read_priority;
  logic [4:0] entry_count;

  modport source (output valid, ok, read_task_id, read_priority, entry_count, input ready);
  modport sink (input valid, ok, read_task_id, read_priority, entry_count, output ready);
endinterface

FILE: rtl/core/priority_sorted_task_table.sv
// Priority sorted task table: insert by priority, remove or read at a position.
// Insert reads each entry from the end and writes it one slot up until the word lands;
// remove moves each entry after the position one slot down; read waits for read data.
// One word at a time, the next taken once the result registers; a full response register
// stalls the sequencer in its done state. Each entry moved takes a read and a write state.
// Reset: count clears to zero, no word pending; entry storage is not cleared.
module priority_sorted_task_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  pstt_req_if.sink   req_i,
  pstt_rsp_if.source rsp_o
);

  pstt_pkg::mem_req_t mem_req;
  pstt_pkg::entry_t   mem_rdata;
  pstt_pkg::rsp_t     seq_rsp;
  pstt_pkg::rsp_t     rsp_q;
  logic               rsp_valid_q;
  logic               room;
  logic               done;

  assign room = !rsp_valid_q || rsp_o.ready;

  pstt_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  pstt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_id_i    (req_i.task_id),
    .req_pri_i   (req_i.task_priority),
    .req_pos_i   (req_i.position),
    .req_ready_o (req_i.ready),
    .room_i      (room),
    .done_o      (done),
    .rsp_o       (seq_rsp),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rsp_q <= seq_rsp;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.ok            = rsp_q.ok;
  assign rsp_o.read_task_id  = rsp_q.id;
  assign rsp_o.read_priority = rsp_q.pri;
  assign rsp_o.entry_count   = rsp_q.count;

endmodule

FILE: rtl/core/pstt_mem.sv
// Entry storage: one write port, one read port with registered read data.
module pstt_mem (
  input  logic               clk_i,
  input  pstt_pkg::mem_req_t req_i,
  output pstt_pkg::entry_t   rdata_o
);

  pstt_pkg::entry_t mem_q [pstt_pkg::DEPTH];
  pstt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pstt_seq.sv
// Sequencer: walks the table one entry at a time to insert, remove or read.
module pstt_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic [1:0]         req_op_i,
  input  logic [7:0]         req_id_i,
  input  logic [7:0]         req_pri_i,
  input  logic [3:0]         req_pos_i,
  output logic               req_ready_o,
  input  logic               room_i,
  output logic               done_o,
  output pstt_pkg::rsp_t     rsp_o,
  output pstt_pkg::mem_req_t mem_req_o,
  input  pstt_pkg::entry_t   mem_rdata_i
);

  localparam int CntW = pstt_pkg::CntW;
  localparam int IdxW = pstt_pkg::IdxW;
  localparam int CmpW = pstt_pkg::CmpW;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_RD  = 7'b0000010,
    S_INS_CMP = 7'b0000100,
    S_REM_RD  = 7'b0001000,
    S_REM_WR  = 7'b0010000,
    S_RD_WAIT = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] k_q, k_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      pri_q, pri_d;
  logic            ok_q, ok_d;
  logic [7:0]      rid_q, rid_d;
  logic [7:0]      rpri_q, rpri_d;
  logic            pos_ok;
  logic            full;
  pstt_pkg::entry_t new_entry;

  assign pos_ok    = CmpW'(req_pos_i) < CmpW'(count_q);
  assign full      = count_q == CntW'(pstt_pkg::DEPTH);
  assign new_entry = '{id: id_q, pri: pri_q};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    k_d       = k_q;
    id_d      = id_q;
    pri_d     = pri_q;
    ok_d      = ok_q;
    rid_d     = rid_q;
    rpri_d    = rpri_q;
    mem_req_o = '0;
    done_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          id_d   = req_id_i;
          pri_d  = req_pri_i;
          ok_d   = 1'b0;
          rid_d  = '0;
          rpri_d = '0;
          mem_req_o.raddr = IdxW'(req_pos_i);
          unique case (req_op_i)
            pstt_pkg::OP_INSERT: begin
              k_d     = count_q;
              state_d = full ? S_DONE : S_INS_RD;
            end
            pstt_pkg::OP_REMOVE: begin
              k_d     = CntW'(req_pos_i);
              state_d = pos_ok ? S_REM_RD : S_DONE;
            end
            pstt_pkg::OP_READ: begin
              state_d = pos_ok ? S_RD_WAIT : S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INS_RD: begin
        if (k_q == '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = '0;
          mem_req_o.wdata = new_entry;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          mem_req_o.raddr = IdxW'(k_q - 1'b1);
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = IdxW'(k_q);
        if (mem_rdata_i.pri <= pri_q) begin
          // found the slot just above all entries of lower or equal priority
          mem_req_o.wdata = new_entry;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          mem_req_o.wdata = mem_rdata_i;
          k_d     = k_q - 1'b1;
          state_d = S_INS_RD;
        end
      end
      S_REM_RD: begin
        if ((k_q + 1'b1) >= count_q) begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          mem_req_o.raddr = IdxW'(k_q + 1'b1);
          state_d = S_REM_WR;
        end
      end
      S_REM_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = IdxW'(k_q);
        mem_req_o.wdata = mem_rdata_i;
        k_d     = k_q + 1'b1;
        state_d = S_REM_RD;
      end
      S_RD_WAIT: begin
        rid_d   = mem_rdata_i.id;
        rpri_d  = mem_rdata_i.pri;
        ok_d    = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (room_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    id_q   <= id_d;
    pri_q  <= pri_d;
    ok_q   <= ok_d;
    rid_q  <= rid_d;
    rpri_q <= rpri_d;
  end

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_o = '{ok: ok_q, id: rid_q, pri: rpri_q,
                   count: pstt_pkg::OutCntW'(count_q)};

endmodule

FILE: rtl/core/pstt_chk.sv
// Port-level checker for the priority sorted task table, bound to the top level.
module pstt_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_ok_i,
  input logic [7:0] rsp_id_i,
  input logic [7:0] rsp_pri_i,
  input logic [4:0] rsp_count_i
);

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_ok_i) &&
      $stable(rsp_id_i) && $stable(rsp_pri_i) && $stable(rsp_count_i))
    else $error("response word changed while stalled");

  // the table works on one word at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ok_i |-> rsp_id_i == 8'd0 && rsp_pri_i == 8'd0)
    else $error("failed word carries entry data");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (pstt_pkg::DEPTH > 31) || (int'(rsp_count_i) <= pstt_pkg::DEPTH))
    else $error("entry count above table depth");

endmodule

bind priority_sorted_task_table pstt_chk u_pstt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_ok_i    (rsp_o.ok),
  .rsp_id_i    (rsp_o.read_task_id),
  .rsp_pri_i   (rsp_o.read_priority),
  .rsp_count_i (rsp_o.entry_count)
);

FILE: tb/priority_sorted_task_table_tb.sv
// Self-checking testbench for the priority sorted task table, with a tracking model in a class.
`timescale 1ns / 1ps

module priority_sorted_task_table_tb;

  localparam logic [1:0] OpUnknown = 2'd3;
  localparam int RandomWords = 1000;
  // Sized for the longest insert per word plus both idle draws, and for the long result holds.
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 48;

  // Tracks table contents in order and holds the results still owed by the block.
  class task_table_model;
    pstt_pkg::entry_t slots[pstt_pkg::DEPTH];
    int fill;
    int peak_fill;
    pstt_pkg::rsp_t awaited[$];
    int errors, checked;
    int n_insert, n_remove, n_read, n_unknown, n_full, n_bad_pos;

    function new();
      fill = 0;
      peak_fill = 0;
      errors = 0;
      checked = 0;
      n_insert = 0;
      n_remove = 0;
      n_read = 0;
      n_unknown = 0;
      n_full = 0;
      n_bad_pos = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] id, logic [7:0] pri,
                               logic [3:0] pos);
      pstt_pkg::rsp_t want;
      int slot;
      want = '0;
      case (op)
        pstt_pkg::OP_INSERT: begin
          n_insert++;
          if (fill >= pstt_pkg::DEPTH) begin
            n_full++;
          end else begin
            // ties land above existing entries, so arrival order holds
            slot = 0;
            while (slot < fill && slots[slot].pri <= pri) slot++;
            for (int i = fill; i > slot; i--) slots[i] = slots[i-1];
            slots[slot].id = id;
            slots[slot].pri = pri;
            fill++;
            want.ok = 1'b1;
          end
        end
        pstt_pkg::OP_REMOVE: begin
          n_remove++;
          if (int'(pos) >= fill) begin
            n_bad_pos++;
          end else begin
            for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            want.ok = 1'b1;
          end
        end
        pstt_pkg::OP_READ: begin
          n_read++;
          if (int'(pos) >= fill) begin
            n_bad_pos++;
          end else begin
            want.ok = 1'b1;
            want.id = slots[pos].id;
            want.pri = slots[pos].pri;
          end
        end
        default: n_unknown++;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      want.count = pstt_pkg::OutCntW'(fill);
      awaited.push_back(want);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_result(pstt_pkg::rsp_t got);
      pstt_pkg::rsp_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing outstanding (ok=%0b count=%0d)",
                         got.ok, got.count));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.ok !== want.ok)
        report($sformatf("word %0d ok %0b, want %0b", checked, got.ok, want.ok));
      if (got.id !== want.id)
        report($sformatf("word %0d task id %0h, want %0h", checked, got.id, want.id));
      if (got.pri !== want.pri)
        report($sformatf("word %0d priority %0h, want %0h", checked, got.pri, want.pri));
      if (got.count !== want.count)
        report($sformatf("word %0d count %0d, want %0d", checked, got.count, want.count));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int cycle_count = 0;
  int rx_hold = 0;
  int tx_streak;
  task_table_model sb;

  pstt_req_if req_bus ();
  pstt_rsp_if rsp_bus ();

  priority_sorted_task_table uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // Zero gap for a run of words now and then, otherwise a random idle gap.
  function automatic int draw_gap(ref int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      streak = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Entered right after an accepting edge (or after reset); returns right after acceptance.
  task automatic send_word(logic [1:0] op, logic [7:0] id, logic [7:0] pri, logic [3:0] pos);
    int gap;
    gap = draw_gap(tx_streak);
    @(negedge clk);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.operation <= op;
    req_bus.task_id <= id;
    req_bus.task_priority <= pri;
    req_bus.position <= pos;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    sb.note_request(op, id, pri, pos);
  endtask

  task automatic drain_outstanding();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus long holds requested by the stimulus.
  initial begin : rx_side
    int stall;
    int rx_streak;
    pstt_pkg::rsp_t got;
    rsp_bus.ready = 1'b0;
    rx_streak = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = draw_gap(rx_streak) + rx_hold;
      rx_hold = 0;
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (rsp_bus.valid !== 1'b1);
      got.ok = rsp_bus.ok;
      got.id = rsp_bus.read_task_id;
      got.pri = rsp_bus.read_priority;
      got.count = rsp_bus.entry_count;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [1:0] op;
    logic [7:0] id, pri;
    logic [3:0] pos;
    logic filling;
    int pick;
    sb = new();
    tx_streak = 0;
    filling = 1'b1;
    rst_n = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.operation = pstt_pkg::OP_INSERT;
    req_bus.task_id = '0;
    req_bus.task_priority = '0;
    req_bus.position = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, extremes, ties, lowest priority, full table
    send_word(pstt_pkg::OP_READ, 8'h00, 8'h00, 4'd0);
    send_word(pstt_pkg::OP_REMOVE, 8'h00, 8'h00, 4'd0);
    send_word(pstt_pkg::OP_INSERT, 8'h00, 8'd128, 4'd0);
    send_word(pstt_pkg::OP_INSERT, 8'hFF, 8'hFF, 4'hF);
    send_word(pstt_pkg::OP_INSERT, 8'h5A, 8'h00, 4'd0);
    send_word(pstt_pkg::OP_INSERT, 8'hA5, 8'd128, 4'd0);
    send_word(pstt_pkg::OP_READ, 8'h00, 8'h00, 4'd0);
    send_word(pstt_pkg::OP_READ, 8'h00, 8'h00, 4'd2);
    send_word(pstt_pkg::OP_READ, 8'h00, 8'h00, 4'd3);
    send_word(OpUnknown, 8'hFF, 8'hFF, 4'hF);
    send_word(pstt_pkg::OP_REMOVE, 8'h00, 8'h00, 4'd1);
    for (int k = 0; sb.fill < pstt_pkg::DEPTH; k++)
      send_word(pstt_pkg::OP_INSERT, 8'(k * 37 + 1), 8'(k * 53), 4'(k));
    send_word(pstt_pkg::OP_INSERT, 8'h77, 8'h00, 4'd0);
    send_word(pstt_pkg::OP_READ, 8'h00, 8'h00, 4'hF);
    send_word(pstt_pkg::OP_REMOVE, 8'h00, 8'h00, 4'hF);
    send_word(pstt_pkg::OP_REMOVE, 8'h00, 8'h00, 4'd0);
    send_word(pstt_pkg::OP_READ, 8'h00, 8'h00, 4'hF);

    // random: drift between filling and draining so every fill level is visited
    for (int n = 0; n < RandomWords; n++) begin
      if (n == 250 || n == 700) rx_hold = 150;
      if (n == 450 || n == 850) drain_outstanding();
      if (sb.fill == pstt_pkg::DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (sb.fill == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) == 0) filling = !filling;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OpUnknown;
      else if (pick < 23) op = pstt_pkg::OP_READ;
      else if (pick < (filling ? 78 : 48)) op = pstt_pkg::OP_INSERT;
      else op = pstt_pkg::OP_REMOVE;
      if (sb.fill > 0 && $urandom_range(0, 9) < 8) pos = 4'($urandom_range(0, sb.fill - 1));
      else pos = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: pri = 8'($urandom_range(0, 7));   // crowd priorities to force ties
        1: pri = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        default: pri = 8'($urandom_range(0, 255));
      endcase
      id = 8'($urandom_range(0, 255));
      send_word(op, id, pri, pos);
    end

    drain_outstanding();
    repeat (DrainCycles) @(posedge clk);

    $display("Run: %0d inserts (%0d refused on a full table), %0d removes, %0d reads",
             sb.n_insert, sb.n_full, sb.n_remove, sb.n_read);
    $display("Run: %0d out-of-range positions, %0d unknown operations, peak fill %0d, %0d checked",
             sb.n_bad_pos, sb.n_unknown, sb.peak_fill, sb.checked);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
